// ===== sv/rtt_pkg.sv =====
// ----------------------------------------------------------------------------
// rtt_pkg
// Shared types and codes for the reaction text tokenizer: token kinds,
// character constants and the request that travels from front to back.
// ----------------------------------------------------------------------------
package rtt_pkg;

	// token kinds on the result channel
	localparam logic [2:0] KIND_END   = 3'd0;
	localparam logic [2:0] KIND_IDENT = 3'd1;
	localparam logic [2:0] KIND_INT   = 3'd2;
	localparam logic [2:0] KIND_PLUS  = 3'd3;
	localparam logic [2:0] KIND_SEMI  = 3'd4;
	localparam logic [2:0] KIND_COLON = 3'd5;
	localparam logic [2:0] KIND_ARROW = 3'd6;
	localparam logic [2:0] KIND_BAD   = 3'd7;

	// work done before the byte itself: replay the stored lexeme or a lone minus
	localparam logic [1:0] PRE_NONE  = 2'd0;
	localparam logic [1:0] PRE_IDENT = 2'd1;
	localparam logic [1:0] PRE_INT   = 2'd2;
	localparam logic [1:0] PRE_MINUS = 2'd3;

	// work done for the byte itself
	localparam logic [2:0] POST_NONE   = 3'd0;
	localparam logic [2:0] POST_STORE  = 3'd1;
	localparam logic [2:0] POST_SINGLE = 3'd2;
	localparam logic [2:0] POST_ARROW  = 3'd3;
	localparam logic [2:0] POST_END    = 3'd4;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;

	localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPW         = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [1:0]  pre;
		logic [2:0]  post;
		logic [2:0]  kind;
		logic [7:0]  ch;
		logic [31:0] value;
		logic        ovf;
		logic [23:0] line;
	} rtt_req_t;

endpackage

// ===== sv/rtt_front.sv =====
// ----------------------------------------------------------------------------
// rtt_front
// Accepts text bytes, tracks the scan mode, line count and decimal value,
// and turns each byte into at most one request for the back end.
// ----------------------------------------------------------------------------
module rtt_front import rtt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        end_of_input,
	input  logic        q_full,
	output logic        q_push,
	output rtt_req_t    q_req
);

	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_SKIP   = 3'd1;
	localparam logic [2:0] MODE_MINUS  = 3'd2;
	localparam logic [2:0] MODE_IDENT  = 3'd3;
	localparam logic [2:0] MODE_NUMBER = 3'd4;

	logic [2:0]  mode_q, mode_d;
	logic [31:0] acc_q, acc_d;
	logic        sat_q, sat_d;
	logic [23:0] line_q, line_d;
	logic        skip_semi_q;

	logic        take;
	logic        is_letter, is_digit, is_tail;
	logic        do_idle;
	logic [35:0] acc_next;
	logic [23:0] line_inc;
	logic [3:0]  digit;

	assign in_stall = q_full;
	assign take     = in_valid && !q_full;

	assign is_letter = (in_byte >= CH_LC_A && in_byte <= CH_LC_Z) ||
	                   (in_byte >= CH_UC_A && in_byte <= CH_UC_Z);
	assign is_digit  = in_byte >= CH_ZERO && in_byte <= CH_NINE;
	assign is_tail   = is_letter || is_digit || in_byte == CH_UNDER ||
	                   in_byte == CH_LBRK || in_byte == CH_RBRK;
	assign digit     = in_byte[3:0];

	// acc * 10 + digit, then saturate at 32 bits
	assign acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {32'd0, digit};
	assign line_inc = (line_q != LINE_MAX) ? line_q + 24'd1 : line_q;

	always_comb begin
		mode_d  = mode_q;
		acc_d   = acc_q;
		sat_d   = sat_q;
		line_d  = line_q;
		do_idle = 1'b0;
		q_req       = '0;
		q_req.pre   = PRE_NONE;
		q_req.post  = POST_NONE;
		q_req.kind  = KIND_BAD;
		q_req.ch    = in_byte;
		q_req.line  = line_q;
		if (end_of_input) begin
			priority case (mode_q)
				MODE_IDENT:  q_req.pre = PRE_IDENT;
				MODE_NUMBER: begin
					q_req.pre   = PRE_INT;
					q_req.value = acc_q;
					q_req.ovf   = sat_q;
				end
				MODE_MINUS:  q_req.pre = PRE_MINUS;
				default:     q_req.pre = PRE_NONE;
			endcase
			q_req.post = POST_END;
			mode_d     = MODE_IDLE;
			acc_d      = '0;
			sat_d      = 1'b0;
		end else begin
			priority case (mode_q)
				MODE_SKIP: begin
					if (in_byte == CH_LF) begin
						line_d = line_inc;
						mode_d = MODE_IDLE;
					end
				end
				MODE_MINUS: begin
					mode_d = MODE_IDLE;
					if (in_byte == CH_GT) begin
						q_req.post = POST_ARROW;
					end else begin
						q_req.pre = PRE_MINUS;
						do_idle   = 1'b1;
					end
				end
				MODE_IDENT: begin
					if (is_tail) begin
						q_req.post = POST_STORE;
					end else begin
						q_req.pre = PRE_IDENT;
						mode_d    = MODE_IDLE;
						do_idle   = 1'b1;
					end
				end
				MODE_NUMBER: begin
					if (is_digit) begin
						q_req.post = POST_STORE;
						if (acc_next[35:32] != 4'd0) begin
							acc_d = '1;
							sat_d = 1'b1;
						end else begin
							acc_d = acc_next[31:0];
						end
					end else begin
						q_req.pre   = PRE_INT;
						q_req.value = acc_q;
						q_req.ovf   = sat_q;
						mode_d      = MODE_IDLE;
						do_idle     = 1'b1;
					end
				end
				default: begin
					mode_d  = MODE_IDLE;
					do_idle = 1'b1;
				end
			endcase

			// scan the byte from idle, after any pending token
			if (do_idle) begin
				priority if (in_byte == CH_SPACE || in_byte == CH_TAB || in_byte == CH_CR) begin
					mode_d = MODE_IDLE;
				end else if (in_byte == CH_LF) begin
					line_d = line_inc;
				end else if (in_byte == CH_HASH) begin
					mode_d = MODE_SKIP;
				end else if (in_byte == CH_PLUS) begin
					q_req.post = POST_SINGLE;
					q_req.kind = KIND_PLUS;
				end else if (in_byte == CH_COLON) begin
					q_req.post = POST_SINGLE;
					q_req.kind = KIND_COLON;
				end else if (in_byte == CH_SEMI) begin
					q_req.post = POST_SINGLE;
					q_req.kind = KIND_SEMI;
					mode_d     = skip_semi_q ? MODE_SKIP : MODE_IDLE;
				end else if (in_byte == CH_MINUS) begin
					mode_d = MODE_MINUS;
				end else if (is_letter || in_byte == CH_UNDER) begin
					q_req.post = POST_STORE;
					mode_d     = MODE_IDENT;
				end else if (is_digit) begin
					q_req.post = POST_STORE;
					acc_d      = {28'd0, digit};
					sat_d      = 1'b0;
					mode_d     = MODE_NUMBER;
				end else begin
					q_req.post = POST_SINGLE;
					q_req.kind = KIND_BAD;
				end
			end
		end
	end

	assign q_push = take && (q_req.pre != PRE_NONE || q_req.post != POST_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			acc_q       <= '0;
			sat_q       <= 1'b0;
			line_q      <= 24'd1;
			skip_semi_q <= 1'b1;
		end else begin
			if (cfg_we) begin
				skip_semi_q <= cfg_wdata;
			end
			if (take) begin
				mode_q <= mode_d;
				acc_q  <= acc_d;
				sat_q  <= sat_d;
				line_q <= line_d;
			end
		end
	end

endmodule

// ===== sv/rtt_queue.sv =====
// ----------------------------------------------------------------------------
// rtt_queue
// Short request queue between the front and the back end.
// ----------------------------------------------------------------------------
module rtt_queue import rtt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  rtt_req_t push_req,
	output logic     full,
	input  logic     pop,
	output rtt_req_t head,
	output logic     head_valid
);

	rtt_req_t       slot_q [QUEUE_DEPTH];
	logic [QPW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPW:0]   count_q;

	assign full       = count_q == (QPW+1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/rtt_back.sv =====
// ----------------------------------------------------------------------------
// rtt_back
// Executes requests: writes lexeme characters to the store, replays the
// store as a token run and emits single tokens, through an output register.
// ----------------------------------------------------------------------------
module rtt_back import rtt_pkg::*; #(
	parameter int MAX_LEXEME = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  rtt_req_t    head,
	input  logic        head_valid,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [7:0]  lexeme_char,
	output logic        last,
	output logic [31:0] value,
	output logic        value_overflow,
	output logic [23:0] line
);

	localparam int IW = $clog2(MAX_LEXEME);
	localparam int LW = $clog2(MAX_LEXEME + 1);

	logic [7:0]    mem [MAX_LEXEME];
	logic [7:0]    rd_q;
	logic [IW-1:0] idx_q, idx_d;
	logic [LW-1:0] len_q, len_d;
	logic          post_q, post_d;
	logic          arr_q, arr_d;

	logic          out_valid_q;
	logic [2:0]    kind_q;
	logic [7:0]    char_q;
	logic          last_q;
	logic [31:0]   value_q;
	logic          ovf_q;
	logic [23:0]   line_q;

	logic          out_ok, ld, we, is_flush, eff_post;
	logic [2:0]    o_kind;
	logic [7:0]    o_ch;
	logic          o_last;
	logic [31:0]   o_value;
	logic          o_ovf;

	assign out_ok   = !out_valid_q || !out_stall;
	assign is_flush = head.pre == PRE_IDENT || head.pre == PRE_INT;
	// skip the pre phase when there is nothing to replay
	assign eff_post = post_q || head.pre == PRE_NONE || (is_flush && len_q == '0);

	always_comb begin
		ld      = 1'b0;
		pop     = 1'b0;
		we      = 1'b0;
		idx_d   = idx_q;
		len_d   = len_q;
		post_d  = post_q;
		arr_d   = arr_q;
		o_kind  = KIND_END;
		o_ch    = 8'd0;
		o_last  = 1'b1;
		o_value = '0;
		o_ovf   = 1'b0;
		if (head_valid) begin
			if (!eff_post) begin
				if (out_ok) begin
					ld = 1'b1;
					if (is_flush) begin
						o_kind  = (head.pre == PRE_INT) ? KIND_INT : KIND_IDENT;
						o_ch    = rd_q;
						o_last  = (LW'(idx_q) + 1'b1) == len_q;
						o_value = head.value;
						o_ovf   = head.ovf;
						if (o_last) begin
							idx_d  = '0;
							len_d  = '0;
							post_d = 1'b1;
						end else begin
							idx_d = idx_q + 1'b1;
						end
					end else begin
						o_kind = KIND_BAD;
						o_ch   = CH_MINUS;
						post_d = 1'b1;
					end
				end
			end else begin
				unique case (head.post)
					POST_STORE: begin
						pop = 1'b1;
						if (len_q < LW'(MAX_LEXEME)) begin
							we    = 1'b1;
							len_d = len_q + 1'b1;
						end
					end
					POST_SINGLE: begin
						if (out_ok) begin
							ld     = 1'b1;
							pop    = 1'b1;
							o_kind = head.kind;
							o_ch   = head.ch;
						end
					end
					POST_END: begin
						if (out_ok) begin
							ld  = 1'b1;
							pop = 1'b1;
						end
					end
					POST_ARROW: begin
						if (out_ok) begin
							ld     = 1'b1;
							o_kind = KIND_ARROW;
							o_ch   = arr_q ? CH_GT : CH_MINUS;
							o_last = arr_q;
							arr_d  = !arr_q;
							pop    = arr_q;
						end
					end
					default: pop = 1'b1;
				endcase
			end
			if (pop) begin
				post_d = 1'b0;
			end
		end
	end

	// store: one write port, one registered read port with write bypass
	always_ff @(posedge clk) begin
		if (we) begin
			mem[len_q[IW-1:0]] <= head.ch;
		end
		if (we && len_q[IW-1:0] == idx_d) begin
			rd_q <= head.ch;
		end else begin
			rd_q <= mem[idx_d];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			len_q       <= '0;
			post_q      <= 1'b0;
			arr_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			idx_q  <= idx_d;
			len_q  <= len_d;
			post_q <= post_d;
			arr_q  <= arr_d;
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			kind_q  <= o_kind;
			char_q  <= o_ch;
			last_q  <= o_last;
			value_q <= o_value;
			ovf_q   <= o_ovf;
			line_q  <= head.line;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign lexeme_char    = char_q;
	assign last           = last_q;
	assign value          = value_q;
	assign value_overflow = ovf_q;
	assign line           = line_q;

endmodule

// ===== sv/reaction_text_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// reaction_text_tokenizer_unit
// Streaming tokenizer for reaction text: bytes in, token character runs out.
//
//   channel   dir  handshake           payload
//   in        in   in_valid/in_stall   in_byte, end_of_input
//   out       out  out_valid/out_stall kind, lexeme_char, last, value,
//                                      value_overflow, line
//   cfg       in   cfg_we              cfg_wdata (skip after semicolon)
//
// The front takes one byte per cycle while the request queue has room.
// The back end writes each character to the store, then replays the store as
// one result per character, so the back end sets the pace for each token.
// Reset clears the control state; the lexeme store needs no clearing pass.
// A stalled output holds its result while the front keeps filling the queue.
// ----------------------------------------------------------------------------
module reaction_text_tokenizer_unit import rtt_pkg::*; #(
	parameter int MAX_LEXEME = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [7:0]  lexeme_char,
	output logic        last,
	output logic [31:0] value,
	output logic        value_overflow,
	output logic [23:0] line
);

	logic     q_push, q_full, q_pop, q_head_valid;
	rtt_req_t q_req, q_head;

	rtt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_req        (q_req)
	);

	rtt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_req   (q_req),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head),
		.head_valid (q_head_valid)
	);

	rtt_back #(
		.MAX_LEXEME (MAX_LEXEME)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (q_head),
		.head_valid     (q_head_valid),
		.pop            (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.lexeme_char    (lexeme_char),
		.last           (last),
		.value          (value),
		.value_overflow (value_overflow),
		.line           (line)
	);

endmodule

// ===== sv/rtt_checker.sv =====
// ----------------------------------------------------------------------------
// rtt_checker
// Port-level checks on the tokenizer result stream.
// ----------------------------------------------------------------------------
module rtt_checker import rtt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  kind,
	input logic [7:0]  lexeme_char,
	input logic        last,
	input logic [31:0] value,
	input logic        value_overflow,
	input logic [23:0] line
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) &&
		$stable(lexeme_char) && $stable(last) && $stable(value) &&
		$stable(value_overflow) && $stable(line))
		else $error("stalled result changed");

	a_end_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_END |-> last && lexeme_char == 8'd0 && value == 32'd0)
		else $error("malformed end token");

	a_value_int_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_INT |-> value == 32'd0 && !value_overflow)
		else $error("value on a non-integer token");

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> line != 24'd0)
		else $error("line number zero");

	a_arrow_head: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ARROW && !last |-> lexeme_char == CH_MINUS)
		else $error("arrow run does not start with minus");

endmodule

bind reaction_text_tokenizer_unit rtt_checker u_rtt_checker (.*);
